// ===== rtl/sqkg_pkg.sv =====
// Shared widths, constants and side-band types of the SPH quartic kernel and gradient core.
package sqkg_pkg;

   localparam int FRAC_W   = 28;
   localparam int DIST_W   = 32;
   localparam int DELTA_W  = 32;
   localparam int SCALE_W  = 48;
   localparam int OUT_W    = 64;
   localparam int Q_W      = 30;
   localparam int RAD_W    = DIST_W + FRAC_W;
   localparam int REM_W    = Q_W + 2;
   localparam int T2_W     = 31;
   localparam int T3_W     = 32;
   localparam int T4_W     = 34;
   localparam int P_W      = 38;
   localparam int M3_W     = 34;
   localparam int M4_W     = 36;
   localparam int NUM_W    = M3_W + FRAC_W;
   localparam int KSHIFT   = 20;
   localparam int GSHIFT   = 16;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;

   localparam logic [Q_W-1:0] HALF_Q28     = Q_W'(32'h0800_0000);
   localparam logic [Q_W-1:0] ONE_HALF_Q28 = Q_W'(32'h1800_0000);
   localparam logic [Q_W-1:0] TWO_HALF_Q28 = Q_W'(32'h2800_0000);

   localparam logic CSR_VALUE_SCALE    = 1'b0;
   localparam logic CSR_GRADIENT_SCALE = 1'b1;

   typedef struct packed {
      logic [DELTA_W-1:0] dz;
      logic [DELTA_W-1:0] dy;
      logic [DELTA_W-1:0] dx;
   } pair_side_type;

   typedef struct packed {
      pair_side_type     pair;
      logic [M4_W-1:0]   m4;
      logic              n4;
      logic              n3;
      logic              outside;
      logic              qzero;
   } div_side_type;

   typedef struct packed {
      pair_side_type     pair;
      logic [M4_W-1:0]   m4;
      logic              n4;
      logic              outside;
      logic              qzero;
   } fin_side_type;

endpackage

// ===== rtl/sph_quartic_kernel_and_gradient_core.sv =====
// Top level of the SPH quartic B-spline kernel and gradient pipeline.
//
//   port group  direction  beat contents
//   req_        in         dist_sq_norm, delta_x, delta_y, delta_z
//   rsp_        out        kernel_value, grad_x, grad_y, grad_z
//   csr_        in/out     value_scale at 0x0, gradient_scale at 0x8
//
// One pair enters per cycle while the pipe is not held; each result passes
// through 30 square root cells, 5 power and sum stages, 62 divider cells,
// two 3-stage multipliers and the output register. Reset clears the stage
// valid bits and both scale registers. The whole pipe holds while a result
// waits at the output register.
module sph_quartic_kernel_and_gradient_core import sqkg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // dist_sq_norm, delta_x, delta_y, delta_z
   input  logic [127:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // kernel_value, grad_x, grad_y, grad_z
   output logic [255:0]        rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   typedef struct packed {
      pair_side_type    pair;
      logic [Q_W-1:0]   q;
      logic             outside;
   } pw_carry_type;

   logic                 en;
   logic [SCALE_W-1:0]   value_scale_ff;
   logic [SCALE_W-1:0]   gradient_scale_ff;
   logic                 csr_write;

   logic                 sq_valid [Q_W+1];
   logic [REM_W-1:0]     sq_rem   [Q_W+1];
   logic [Q_W-1:0]       sq_root  [Q_W+1];
   logic [RAD_W-1:0]     sq_rad   [Q_W+1];
   pair_side_type        sq_side  [Q_W+1];

   logic                 p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff;
   pw_carry_type         c1_ff, c2_ff, c3_ff, c4_ff, c1_in;
   logic [Q_W-1:0]       t1_ff [3], t1_in [3];
   logic [Q_W-1:0]       t2b_ff [3], t3b_ff [3];
   logic [T2_W-1:0]      t2_ff [3], t2_in [3];
   logic [T3_W-1:0]      t3_ff [3], t3_in [3], t3c_ff [3];
   logic [T4_W-1:0]      t4_ff [3], t4_in [3];
   logic [2*Q_W-1:0]     prod2 [3];
   logic [T2_W+Q_W-1:0]  prod3 [3];
   logic [T3_W+Q_W-1:0]  prod4 [3];
   logic [P_W-1:0]       p3, p4;
   logic [P_W-1:0]       p3_abs, p4_abs;
   logic [NUM_W-1:0]     num_ff;
   logic [Q_W-1:0]       den_ff;
   div_side_type         dside_ff, dside_in;

   logic                 dv_valid [NUM_W+1];
   logic [Q_W-1:0]       dv_rem   [NUM_W+1];
   logic [NUM_W-1:0]     dv_nq    [NUM_W+1];
   logic [Q_W-1:0]       dv_den   [NUM_W+1];
   div_side_type         dv_side  [NUM_W+1];

   logic                 gneg;
   logic [SCALE_W-1:0]   gmag;
   fin_side_type         fin_in, fin_out;
   logic                 s_valid;
   logic [OUT_W-1:0]     smag;
   logic                 sneg;
   logic [DELTA_W-1:0]   dvec [3];
   logic [DELTA_W-1:0]   dmag [3];
   logic                 dneg [3];
   logic [OUT_W-1:0]     gmag_out [3];
   logic                 gneg_out [3];
   logic                 gmask_out [3];
   logic                 k_valid;
   logic [OUT_W-1:0]     kmag;
   logic                 kneg;
   logic                 kmask;

   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     kernel_ff, kernel_in;
   logic [OUT_W-1:0]     grad_ff [3], grad_in [3];

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && !reset;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_scale_ff    <= '0;
         gradient_scale_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3])
            CSR_VALUE_SCALE: begin
               value_scale_ff <= csr_pwdata[SCALE_W-1:0];
            end
            CSR_GRADIENT_SCALE: begin
               gradient_scale_ff <= csr_pwdata[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         CSR_VALUE_SCALE:    csr_prdata = CSR_DW'(value_scale_ff);
         CSR_GRADIENT_SCALE: csr_prdata = CSR_DW'(gradient_scale_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign sq_valid[0]   = req_tvalid;
   assign sq_rem[0]     = '0;
   assign sq_root[0]    = '0;
   assign sq_rad[0]     = {req_tdata[DIST_W-1:0], {FRAC_W{1'b0}}};
   assign sq_side[0].dx = req_tdata[63:32];
   assign sq_side[0].dy = req_tdata[95:64];
   assign sq_side[0].dz = req_tdata[127:96];

   for (genvar i = 0; i < Q_W; i++) begin : g_sqrt
      sqkg_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (sq_valid[i]),
         .up_rem   (sq_rem[i]),
         .up_root  (sq_root[i]),
         .up_rad   (sq_rad[i]),
         .up_side  (sq_side[i]),
         .dn_valid (sq_valid[i+1]),
         .dn_rem   (sq_rem[i+1]),
         .dn_root  (sq_root[i+1]),
         .dn_rad   (sq_rad[i+1]),
         .dn_side  (sq_side[i+1])
      );
   end

   always_comb begin
      c1_in.pair    = sq_side[Q_W];
      c1_in.q       = sq_root[Q_W];
      c1_in.outside = sq_root[Q_W] >= TWO_HALF_Q28;
      t1_in[0] = c1_in.outside ? '0 : TWO_HALF_Q28 - sq_root[Q_W];
      t1_in[1] = (sq_root[Q_W] < ONE_HALF_Q28) ? ONE_HALF_Q28 - sq_root[Q_W] : '0;
      t1_in[2] = (sq_root[Q_W] < HALF_Q28) ? HALF_Q28 - sq_root[Q_W] : '0;
      for (int k = 0; k < 3; k++) begin
         prod2[k] = (2*Q_W)'(t1_ff[k]) * (2*Q_W)'(t1_ff[k]);
         t2_in[k] = T2_W'(prod2[k] >> FRAC_W);
         prod3[k] = (T2_W+Q_W)'(t2_ff[k]) * (T2_W+Q_W)'(t2b_ff[k]);
         t3_in[k] = T3_W'(prod3[k] >> FRAC_W);
         prod4[k] = (T3_W+Q_W)'(t3_ff[k]) * (T3_W+Q_W)'(t3b_ff[k]);
         t4_in[k] = T4_W'(prod4[k] >> FRAC_W);
      end
      p3 = P_W'(t3c_ff[0]) - (P_W'(t3c_ff[1]) << 2) - P_W'(t3c_ff[1])
         + (P_W'(t3c_ff[2]) << 3) + (P_W'(t3c_ff[2]) << 1);
      p4 = P_W'(t4_ff[0]) - (P_W'(t4_ff[1]) << 2) - P_W'(t4_ff[1])
         + (P_W'(t4_ff[2]) << 3) + (P_W'(t4_ff[2]) << 1);
      p3_abs = p3[P_W-1] ? P_W'(-p3) : p3;
      p4_abs = p4[P_W-1] ? P_W'(-p4) : p4;
      dside_in.pair    = c4_ff.pair;
      dside_in.m4      = M4_W'(p4_abs);
      dside_in.n4      = p4[P_W-1];
      dside_in.n3      = p3[P_W-1];
      dside_in.outside = c4_ff.outside;
      dside_in.qzero   = c4_ff.q == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= sq_valid[Q_W];
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
      end
      if (en) begin
         c1_ff <= c1_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         for (int k = 0; k < 3; k++) begin
            t1_ff[k]  <= t1_in[k];
            t2_ff[k]  <= t2_in[k];
            t2b_ff[k] <= t1_ff[k];
            t3_ff[k]  <= t3_in[k];
            t3b_ff[k] <= t2b_ff[k];
            t4_ff[k]  <= t4_in[k];
            t3c_ff[k] <= t3_ff[k];
         end
         num_ff   <= {M3_W'(p3_abs), {FRAC_W{1'b0}}};
         den_ff   <= c4_ff.q;
         dside_ff <= dside_in;
      end
   end

   assign dv_valid[0] = p5_valid_ff;
   assign dv_rem[0]   = '0;
   assign dv_nq[0]    = num_ff;
   assign dv_den[0]   = den_ff;
   assign dv_side[0]  = dside_ff;

   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      sqkg_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (dv_valid[i]),
         .up_rem   (dv_rem[i]),
         .up_nq    (dv_nq[i]),
         .up_den   (dv_den[i]),
         .up_side  (dv_side[i]),
         .dn_valid (dv_valid[i+1]),
         .dn_rem   (dv_rem[i+1]),
         .dn_nq    (dv_nq[i+1]),
         .dn_den   (dv_den[i+1]),
         .dn_side  (dv_side[i+1])
      );
   end

   always_comb begin
      gneg           = gradient_scale_ff[SCALE_W-1];
      gmag           = gneg ? SCALE_W'(-gradient_scale_ff) : gradient_scale_ff;
      fin_in.pair    = dv_side[NUM_W].pair;
      fin_in.m4      = dv_side[NUM_W].m4;
      fin_in.n4      = dv_side[NUM_W].n4;
      fin_in.outside = dv_side[NUM_W].outside;
      fin_in.qzero   = dv_side[NUM_W].qzero;
   end

   sqkg_mul_sat #(
      .AW    (SCALE_W),
      .BW    (NUM_W),
      .SHIFT (KSHIFT),
      .SW    ($bits(fin_side_type))
   ) u_smag (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (dv_valid[NUM_W]),
      .up_a     (gmag),
      .up_b     (dv_nq[NUM_W]),
      .up_neg   (gneg ^ dv_side[NUM_W].n3),
      .up_side  (fin_in),
      .dn_valid (s_valid),
      .dn_mag   (smag),
      .dn_neg   (sneg),
      .dn_side  (fin_out)
   );

   always_comb begin
      dvec[0] = fin_out.pair.dx;
      dvec[1] = fin_out.pair.dy;
      dvec[2] = fin_out.pair.dz;
      for (int k = 0; k < 3; k++) begin
         dneg[k] = dvec[k][DELTA_W-1];
         dmag[k] = dneg[k] ? DELTA_W'(-dvec[k]) : dvec[k];
      end
   end

   sqkg_mul_sat #(
      .AW    (SCALE_W),
      .BW    (M4_W),
      .SHIFT (KSHIFT),
      .SW    (1)
   ) u_kernel (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (s_valid),
      .up_a     (value_scale_ff),
      .up_b     (fin_out.m4),
      .up_neg   (fin_out.n4),
      .up_side  (fin_out.outside),
      .dn_valid (k_valid),
      .dn_mag   (kmag),
      .dn_neg   (kneg),
      .dn_side  (kmask)
   );

   for (genvar k = 0; k < 3; k++) begin : g_grad
      sqkg_mul_sat #(
         .AW    (OUT_W),
         .BW    (DELTA_W),
         .SHIFT (GSHIFT),
         .SW    (1)
      ) u_mul (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (s_valid),
         .up_a     (smag),
         .up_b     (dmag[k]),
         .up_neg   (sneg ^ dneg[k]),
         .up_side  (fin_out.outside || fin_out.qzero),
         .dn_valid (),
         .dn_mag   (gmag_out[k]),
         .dn_neg   (gneg_out[k]),
         .dn_side  (gmask_out[k])
      );
   end

   always_comb begin
      kernel_in = kmask ? '0 : (kneg ? OUT_W'(-kmag) : kmag);
      for (int k = 0; k < 3; k++) begin
         grad_in[k] = gmask_out[k] ? '0 : (gneg_out[k] ? OUT_W'(-gmag_out[k]) : gmag_out[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= k_valid;
      end
      if (en) begin
         kernel_ff <= kernel_in;
         for (int k = 0; k < 3; k++) begin
            grad_ff[k] <= grad_in[k];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {grad_ff[2], grad_ff[1], grad_ff[0], kernel_ff};

endmodule

// ===== rtl/sqkg_sqrt_cell.sv =====
// One bit of the pipelined integer square root, two radicand bits per cell.
module sqkg_sqrt_cell import sqkg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 up_valid,
   input  logic [REM_W-1:0]     up_rem,
   input  logic [Q_W-1:0]       up_root,
   input  logic [RAD_W-1:0]     up_rad,
   input  pair_side_type        up_side,
   output logic                 dn_valid,
   output logic [REM_W-1:0]     dn_rem,
   output logic [Q_W-1:0]       dn_root,
   output logic [RAD_W-1:0]     dn_rad,
   output pair_side_type        dn_side
);

   logic                 valid_ff;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [Q_W-1:0]       root_ff, root_in;
   logic [RAD_W-1:0]     rad_ff, rad_in;
   pair_side_type        side_ff;
   logic [REM_W+1:0]     cur;
   logic [REM_W+1:0]     trial;
   logic                 ge;

   always_comb begin
      cur     = {up_rem, up_rad[RAD_W-1 -: 2]};
      trial   = (REM_W+2)'({up_root, 2'b01});
      ge      = cur >= trial;
      rem_in  = ge ? REM_W'(cur - trial) : REM_W'(cur);
      root_in = {up_root[Q_W-2:0], ge};
      rad_in  = {up_rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;
   assign dn_side  = side_ff;

endmodule

// ===== rtl/sqkg_div_cell.sv =====
// One quotient bit of the pipelined restoring divider.
module sqkg_div_cell import sqkg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 up_valid,
   input  logic [Q_W-1:0]       up_rem,
   input  logic [NUM_W-1:0]     up_nq,
   input  logic [Q_W-1:0]       up_den,
   input  div_side_type         up_side,
   output logic                 dn_valid,
   output logic [Q_W-1:0]       dn_rem,
   output logic [NUM_W-1:0]     dn_nq,
   output logic [Q_W-1:0]       dn_den,
   output div_side_type         dn_side
);

   logic                 valid_ff;
   logic [Q_W-1:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]     nq_ff, nq_in;
   logic [Q_W-1:0]       den_ff;
   div_side_type         side_ff;
   logic [Q_W:0]         cur;
   logic                 ge;

   always_comb begin
      cur    = {up_rem, up_nq[NUM_W-1]};
      ge     = cur >= (Q_W+1)'(up_den);
      rem_in = ge ? Q_W'(cur - (Q_W+1)'(up_den)) : Q_W'(cur);
      nq_in  = {up_nq[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
      if (en) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         den_ff  <= up_den;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_nq    = nq_ff;
   assign dn_den   = den_ff;
   assign dn_side  = side_ff;

endmodule

// ===== rtl/sqkg_mul_sat.sv =====
// Three-stage split multiplier giving a shifted magnitude saturated to the signed 64-bit limit.
module sqkg_mul_sat import sqkg_pkg::*; #(
   parameter int AW    = 48,
   parameter int BW    = 36,
   parameter int SHIFT = 20,
   parameter int SW    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  logic [AW-1:0]     up_a,
   input  logic [BW-1:0]     up_b,
   input  logic              up_neg,
   input  logic [SW-1:0]     up_side,
   output logic              dn_valid,
   output logic [OUT_W-1:0]  dn_mag,
   output logic              dn_neg,
   output logic [SW-1:0]     dn_side
);

   localparam int AL  = AW / 2;
   localparam int AH  = AW - AL;
   localparam int BL  = BW / 2;
   localparam int BH  = BW - BL;
   localparam int PW  = AW + BW;
   localparam int PSW = PW - SHIFT;

   logic [2:0]            valid_ff;
   logic [2:0]            neg_ff;
   logic [SW-1:0]         side1_ff, side2_ff, side3_ff;
   logic [AL+BL-1:0]      pll_ff, pll_in;
   logic [AL+BH-1:0]      plh_ff, plh_in;
   logic [AH+BL-1:0]      phl_ff, phl_in;
   logic [AH+BH-1:0]      phh_ff, phh_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [OUT_W-1:0]      mag_ff, mag_in;
   logic [PSW-1:0]        shifted;
   logic [OUT_W-1:0]      lim;

   always_comb begin
      pll_in  = up_a[AL-1:0] * up_b[BL-1:0];
      plh_in  = up_a[AL-1:0] * up_b[BW-1:BL];
      phl_in  = up_a[AW-1:AL] * up_b[BL-1:0];
      phh_in  = up_a[AW-1:AL] * up_b[BW-1:BL];
      prod_in = (PW'(phh_ff) << (AL + BL)) + (PW'(phl_ff) << AL)
              + (PW'(plh_ff) << BL) + PW'(pll_ff);
      shifted = prod_ff[PW-1:SHIFT];
      lim     = neg_ff[1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      mag_in  = (shifted > PSW'(lim)) ? lim : OUT_W'(shifted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], up_valid};
      end
      if (en) begin
         neg_ff   <= {neg_ff[1:0], up_neg};
         side1_ff <= up_side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         pll_ff   <= pll_in;
         plh_ff   <= plh_in;
         phl_ff   <= phl_in;
         phh_ff   <= phh_in;
         prod_ff  <= prod_in;
         mag_ff   <= mag_in;
      end
   end

   assign dn_valid = valid_ff[2];
   assign dn_mag   = mag_ff;
   assign dn_neg   = neg_ff[2];
   assign dn_side  = side3_ff;

endmodule
